// File: rtl/pcm_pkg.sv
// Package for the pseudocolor palette mapper: mode codes, stage types, helpers.
`default_nettype none
package pcm_pkg;

  // palette_mode register codes
  localparam logic [3:0] MODE_GRAY    = 4'd0;
  localparam logic [3:0] MODE_REDBLUE = 4'd1;
  localparam logic [3:0] MODE_RGB     = 4'd2;
  localparam logic [3:0] MODE_HOT     = 4'd3;
  localparam logic [3:0] MODE_COLD    = 4'd4;
  localparam logic [3:0] MODE_RAIN    = 4'd5;
  localparam logic [3:0] MODE_RAIN2   = 4'd6;
  localparam logic [3:0] MODE_RAIN4   = 4'd7;
  localparam logic [3:0] MODE_RAIN8   = 4'd8;
  localparam logic [3:0] MODE_RAIN16  = 4'd9;
  localparam logic [3:0] MODE_RAIN32  = 4'd10;

  localparam logic [3:0] MODE_RESET   = MODE_RAIN2;

  localparam int unsigned PIX_W  = 8;
  localparam int unsigned MODE_W = 4;

  localparam logic [PIX_W-1:0] HOT_THIRD1 = 8'd85;
  localparam logic [PIX_W-1:0] HOT_THIRD2 = 8'd170;
  localparam logic [PIX_W-1:0] FULL       = 8'd255;

  // palette family, rainbow variants folded into one
  typedef enum logic [2:0] {
    PAL_GRAY    = 3'd0,
    PAL_REDBLUE = 3'd1,
    PAL_RGB     = 3'd2,
    PAL_HOT     = 3'd3,
    PAL_COLD    = 3'd4,
    PAL_RAIN    = 3'd5,
    PAL_BLACK   = 3'd6
  } pal_t;

  // decode stage -> ramp stage
  typedef struct packed {
    pal_t             pal;
    logic [1:0]       seg;
    logic [PIX_W-1:0] off;
  } dec_t;

  // ramp stage -> select stage
  typedef struct packed {
    pal_t             pal;
    logic [1:0]       seg;
    logic [PIX_W-1:0] ramp;
    logic [PIX_W-1:0] ramp_n;
  } ramp_t;

  function automatic pal_t pal_of(input logic [MODE_W-1:0] mode);
    pal_t p;
    case (mode)
      MODE_GRAY:    p = PAL_GRAY;
      MODE_REDBLUE: p = PAL_REDBLUE;
      MODE_RGB:     p = PAL_RGB;
      MODE_HOT:     p = PAL_HOT;
      MODE_COLD:    p = PAL_COLD;
      MODE_RAIN, MODE_RAIN2, MODE_RAIN4, MODE_RAIN8, MODE_RAIN16, MODE_RAIN32:
                    p = PAL_RAIN;
      default:      p = PAL_BLACK;
    endcase
    return p;
  endfunction

  // quantized rainbow keeps the top (mode-5) bits of the index
  function automatic logic [PIX_W-1:0] quant_mask(input logic [MODE_W-1:0] mode);
    logic [PIX_W-1:0] m;
    case (mode)
      MODE_RAIN2:  m = 8'h80;
      MODE_RAIN4:  m = 8'hC0;
      MODE_RAIN8:  m = 8'hE0;
      MODE_RAIN16: m = 8'hF0;
      MODE_RAIN32: m = 8'hF8;
      default:     m = 8'hFF;
    endcase
    return m;
  endfunction

endpackage
`default_nettype wire

// File: rtl/pcm_decode.sv
// Stage 1: quantize the index, pick palette segment and in-segment offset.
`default_nettype none
module pcm_decode (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_vld,
  input  wire logic [pcm_pkg::PIX_W-1:0]   in_idx,
  input  wire logic [pcm_pkg::MODE_W-1:0]  in_mode,
  output logic                             dec_vld,
  output pcm_pkg::dec_t                    dec
);

  logic           vld_r;
  pcm_pkg::dec_t  dec_r, dec_nxt;
  logic [pcm_pkg::PIX_W-1:0] q;

  always_comb begin
    q = in_idx & pcm_pkg::quant_mask(in_mode);
    dec_nxt.pal = pcm_pkg::pal_of(in_mode);
    dec_nxt.seg = 2'd0;
    dec_nxt.off = in_idx;
    case (dec_nxt.pal)
      pcm_pkg::PAL_RGB: begin
        dec_nxt.seg = {1'b0, in_idx[7]};
        dec_nxt.off = {1'b0, in_idx[6:0]};
      end
      pcm_pkg::PAL_HOT: begin
        if (in_idx < pcm_pkg::HOT_THIRD1) begin
          dec_nxt.seg = 2'd0;
          dec_nxt.off = in_idx;
        end else if (in_idx < pcm_pkg::HOT_THIRD2) begin
          dec_nxt.seg = 2'd1;
          dec_nxt.off = in_idx - pcm_pkg::HOT_THIRD1;
        end else begin
          dec_nxt.seg = 2'd2;
          dec_nxt.off = in_idx - pcm_pkg::HOT_THIRD2;
        end
      end
      pcm_pkg::PAL_RAIN: begin
        dec_nxt.seg = q[7:6];
        dec_nxt.off = {2'b00, q[5:0]};
      end
      default: begin
        dec_nxt.seg = 2'd0;
        dec_nxt.off = in_idx;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    dec_r <= dec_nxt;
  end

  assign dec_vld = vld_r;
  assign dec     = dec_r;

endmodule
`default_nettype wire

// File: rtl/pcm_ramp.sv
// Stage 2: scale the offset by the palette slope, form its complement.
`default_nettype none
module pcm_ramp (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           dec_vld,
  input  wire pcm_pkg::dec_t  dec,
  output logic                rmp_vld,
  output pcm_pkg::ramp_t      rmp
);

  logic            vld_r;
  pcm_pkg::ramp_t  rmp_r, rmp_nxt;
  logic [pcm_pkg::PIX_W-1:0] r;

  always_comb begin
    case (dec.pal)
      pcm_pkg::PAL_RGB:  r = {dec.off[6:0], 1'b0};
      pcm_pkg::PAL_HOT:  r = dec.off + {dec.off[6:0], 1'b0};
      pcm_pkg::PAL_RAIN: r = {dec.off[5:0], 2'b00};
      default:           r = dec.off;
    endcase
    rmp_nxt.pal    = dec.pal;
    rmp_nxt.seg    = dec.seg;
    rmp_nxt.ramp   = r;
    rmp_nxt.ramp_n = ~r;   // 255 - r
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= dec_vld;
    end
  end

  always_ff @(posedge clk) begin
    rmp_r <= rmp_nxt;
  end

  assign rmp_vld = vld_r;
  assign rmp     = rmp_r;

endmodule
`default_nettype wire

// File: rtl/pcm_select.sv
// Stage 3: route ramp, inverse ramp, zero or full to each color channel.
`default_nettype none
module pcm_select (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       rmp_vld,
  input  wire pcm_pkg::ramp_t             rmp,
  output logic                            out_vld,
  output logic [pcm_pkg::PIX_W-1:0]       out_r,
  output logic [pcm_pkg::PIX_W-1:0]       out_g,
  output logic [pcm_pkg::PIX_W-1:0]       out_b
);

  logic                      vld_r;
  logic [pcm_pkg::PIX_W-1:0] r_r, g_r, b_r;
  logic [pcm_pkg::PIX_W-1:0] r_nxt, g_nxt, b_nxt;
  logic [pcm_pkg::PIX_W-1:0] x, xn;

  always_comb begin
    x     = rmp.ramp;
    xn    = rmp.ramp_n;
    r_nxt = '0;
    g_nxt = '0;
    b_nxt = '0;
    case (rmp.pal)
      pcm_pkg::PAL_GRAY: begin
        r_nxt = x; g_nxt = x; b_nxt = x;
      end
      pcm_pkg::PAL_REDBLUE: begin
        r_nxt = xn; b_nxt = x;
      end
      pcm_pkg::PAL_RGB: begin
        if (rmp.seg[0]) begin
          g_nxt = xn; b_nxt = x;
        end else begin
          r_nxt = xn; g_nxt = x;
        end
      end
      pcm_pkg::PAL_HOT: begin
        case (rmp.seg)
          2'd0:    r_nxt = x;
          2'd1: begin
            r_nxt = pcm_pkg::FULL; g_nxt = x;
          end
          default: begin
            r_nxt = pcm_pkg::FULL; g_nxt = pcm_pkg::FULL; b_nxt = x;
          end
        endcase
      end
      pcm_pkg::PAL_COLD: begin
        r_nxt = x; g_nxt = xn; b_nxt = pcm_pkg::FULL;
      end
      pcm_pkg::PAL_RAIN: begin
        case (rmp.seg)
          2'd0: begin
            r_nxt = pcm_pkg::FULL; g_nxt = x;
          end
          2'd1: begin
            r_nxt = xn; g_nxt = pcm_pkg::FULL;
          end
          2'd2: begin
            g_nxt = xn; b_nxt = x;
          end
          default: begin
            r_nxt = x; b_nxt = pcm_pkg::FULL;
          end
        endcase
      end
      default: begin
        r_nxt = '0; g_nxt = '0; b_nxt = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= rmp_vld;
    end
  end

  always_ff @(posedge clk) begin
    r_r <= r_nxt;
    g_r <= g_nxt;
    b_r <= b_nxt;
  end

  assign out_vld = vld_r;
  assign out_r   = r_r;
  assign out_g   = g_r;
  assign out_b   = b_r;

endmodule
`default_nettype wire

// File: rtl/pseudocolor_palette_mapper.sv
// Top level of the pseudocolor palette mapper: index to RGB through a selected palette.
//
//  channel   direction  handshake          payload
//  --------  ---------  -----------------  --------------------------------------
//  input     in         start / busy       in_pixel_index[7:0]
//  result    out        out_valid strobe   out_red, out_green, out_blue [7:0]
//  config    in         cfg_we             cfg_wdata[3:0] -> palette_mode
//
//  One pixel per clock while busy is low. A transfer passes from the accepting
//  edge through the input register, decode, ramp and select registers to the
//  out_valid strobe. The pipeline never stalls; each valid bit moves each cycle.
//  busy is set by the synchronous reset and clears at the first edge with rst_n high.
//  palette_mode resets to 6 (two-level rainbow) and is sampled per transfer.
`default_nettype none
module pseudocolor_palette_mapper (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  // input transfer
  input  wire logic                        start,
  output logic                             busy,
  input  wire logic [pcm_pkg::PIX_W-1:0]   in_pixel_index,
  // configuration
  input  wire logic                        cfg_we,
  input  wire logic [pcm_pkg::MODE_W-1:0]  cfg_wdata,
  // result transfer
  output logic                             out_valid,
  output logic [pcm_pkg::PIX_W-1:0]        out_red,
  output logic [pcm_pkg::PIX_W-1:0]        out_green,
  output logic [pcm_pkg::PIX_W-1:0]        out_blue
);

  // control
  logic                        busy_r;
  logic [pcm_pkg::MODE_W-1:0]  mode_r;

  // stage 0: captured transfer
  logic                        s0_vld_r;
  logic [pcm_pkg::PIX_W-1:0]   s0_idx_r;
  logic [pcm_pkg::MODE_W-1:0]  s0_mode_r;

  logic                        accept;

  logic                        dec_vld;
  pcm_pkg::dec_t               dec;
  logic                        rmp_vld;
  pcm_pkg::ramp_t              rmp;

  assign accept = start && !busy_r;
  assign busy   = busy_r;

  // busy holds off input for the cycle right after reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r   <= 1'b1;
      mode_r   <= pcm_pkg::MODE_RESET;
      s0_vld_r <= 1'b0;
    end else begin
      busy_r   <= 1'b0;
      s0_vld_r <= accept;
      if (cfg_we) begin
        mode_r <= cfg_wdata;
      end
    end
  end

  // payload with its mode travels down the pipe
  always_ff @(posedge clk) begin
    s0_idx_r  <= in_pixel_index;
    s0_mode_r <= mode_r;
  end

  pcm_decode u_decode (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_vld  (s0_vld_r),
    .in_idx  (s0_idx_r),
    .in_mode (s0_mode_r),
    .dec_vld (dec_vld),
    .dec     (dec)
  );

  pcm_ramp u_ramp (
    .clk     (clk),
    .rst_n   (rst_n),
    .dec_vld (dec_vld),
    .dec     (dec),
    .rmp_vld (rmp_vld),
    .rmp     (rmp)
  );

  pcm_select u_select (
    .clk     (clk),
    .rst_n   (rst_n),
    .rmp_vld (rmp_vld),
    .rmp     (rmp),
    .out_vld (out_valid),
    .out_r   (out_red),
    .out_g   (out_green),
    .out_b   (out_blue)
  );

endmodule
`default_nettype wire

// File: rtl/pcm_checker.sv
// Port-level checker for the pseudocolor palette mapper, with its bind.
`default_nettype none
module pcm_checker (
  input wire logic clk,
  input wire logic rst_n,
  input wire logic start,
  input wire logic busy,
  input wire logic out_valid
);

  // every transfer comes out after passing the whole pipe
  a_accept_to_out: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##4 out_valid)
    else $error("transfer not delivered after 4 cycles");

  // no result without a matching earlier transfer
  a_out_has_source: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy, 4))
    else $error("result strobe without matching transfer");

  // reset flushes the result strobe
  a_reset_flush: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("out_valid high after reset");

  // once busy drops after reset it never rises again
  a_busy_short: assert property (@(posedge clk) disable iff (!rst_n)
    !busy |=> !busy)
    else $error("busy reasserted outside reset recovery");

endmodule

bind pseudocolor_palette_mapper pcm_checker u_pcm_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .out_valid (out_valid)
);
`default_nettype wire

// File: tb/tb_pseudocolor_palette_mapper.sv
// Self-checking testbench for pseudocolor_palette_mapper: every palette mode, predicted colors.
`default_nettype none
module tb_pseudocolor_palette_mapper;
  timeunit 1ns;
  timeprecision 1ps;

  // Codes past the last rainbow mode have no palette and map to black.
  localparam logic [pcm_pkg::MODE_W-1:0] MODE_UNUSED_FIRST = 4'd11;
  localparam logic [pcm_pkg::MODE_W-1:0] MODE_LAST         = 4'd15;
  localparam int NUM_MODES       = 16;

  localparam int PIPE_LATENCY    = 4;    // accept edge to result edge
  localparam int IDLE_LIMIT      = 1000; // cycles with no transfer before timeout
  localparam int ITEMS_PER_MODE  = 72;   // 16 modes x 72 ~ 1150 random pixels
  localparam int MAX_BURST       = 24;
  localparam int MAX_GAP         = 6;

  // Segment boundaries of the rgb, hot and rainbow ramps, plus both ends.
  localparam logic [pcm_pkg::PIX_W-1:0] BREAK_POINTS [12] =
    '{8'd0, 8'd63, 8'd64, 8'd84, 8'd85, 8'd127, 8'd128, 8'd169, 8'd170,
      8'd191, 8'd192, 8'd255};

  typedef struct packed {
    logic [pcm_pkg::PIX_W-1:0] red;
    logic [pcm_pkg::PIX_W-1:0] green;
    logic [pcm_pkg::PIX_W-1:0] blue;
  } rgb_t;

  logic                       clk            = 1'b0;
  logic                       rst_n          = 1'b0;
  logic                       start          = 1'b0;
  logic [pcm_pkg::PIX_W-1:0]  in_pixel_index = '0;
  logic                       cfg_we         = 1'b0;
  logic [pcm_pkg::MODE_W-1:0] cfg_wdata      = '0;
  logic                       busy;
  logic                       out_valid;
  logic [pcm_pkg::PIX_W-1:0]  out_red;
  logic [pcm_pkg::PIX_W-1:0]  out_green;
  logic [pcm_pkg::PIX_W-1:0]  out_blue;

  rgb_t                       expected_colors[$];  // one entry per accepted pixel, oldest first
  // palette the block holds right now
  logic [pcm_pkg::MODE_W-1:0] active_mode  = pcm_pkg::MODE_RESET;
  // palette last requested by the stimulus
  logic [pcm_pkg::MODE_W-1:0] written_mode = pcm_pkg::MODE_RESET;
  int                         error_count  = 0;
  int                         idle_cycles  = 0;
  int                         burst_left   = 0;
  bit                         no_gaps      = 1'b0;

  always #5 clk = ~clk;

  pseudocolor_palette_mapper dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_pixel_index (in_pixel_index),
    .cfg_we         (cfg_we),
    .cfg_wdata      (cfg_wdata),
    .out_valid      (out_valid),
    .out_red        (out_red),
    .out_green      (out_green),
    .out_blue       (out_blue)
  );

  // ---------------------------------------------------------------------------
  // Color prediction
  // ---------------------------------------------------------------------------

  // Four 64-wide segments: red->yellow, yellow->green, green->blue, blue->violet.
  function automatic rgb_t rainbow_color(input logic [pcm_pkg::PIX_W-1:0] idx);
    rgb_t c;
    int   i;
    i = idx;
    if (i < 64) begin
      c.red = 8'd255; c.green = 8'(4 * i); c.blue = 8'd0;
    end else if (i < 128) begin
      c.red = 8'(255 - 4 * (i - 64)); c.green = 8'd255; c.blue = 8'd0;
    end else if (i < 192) begin
      c.red = 8'd0; c.green = 8'(255 - 4 * (i - 128)); c.blue = 8'(4 * (i - 128));
    end else begin
      c.red = 8'(4 * (i - 192)); c.green = 8'd0; c.blue = 8'd255;
    end
    return c;
  endfunction

  function automatic rgb_t palette_color(input logic [pcm_pkg::MODE_W-1:0] mode,
                                         input logic [pcm_pkg::PIX_W-1:0]  idx);
    rgb_t c;
    int   i;
    int   drop;
    i = idx;
    c = '0;
    case (mode)
      pcm_pkg::MODE_GRAY: begin
        c.red = idx; c.green = idx; c.blue = idx;
      end
      pcm_pkg::MODE_REDBLUE: begin
        c.red = 8'(255 - i); c.green = 8'd0; c.blue = idx;
      end
      pcm_pkg::MODE_RGB: begin
        if (i < 128) begin
          c.red = 8'(255 - 2 * i); c.green = 8'(2 * i); c.blue = 8'd0;
        end else begin
          c.red = 8'd0; c.green = 8'(255 - 2 * (i - 128)); c.blue = 8'(2 * (i - 128));
        end
      end
      pcm_pkg::MODE_HOT: begin
        if (i < 85) begin
          c.red = 8'(3 * i); c.green = 8'd0; c.blue = 8'd0;
        end else if (i < 170) begin
          c.red = 8'd255; c.green = 8'(3 * (i - 85)); c.blue = 8'd0;
        end else begin
          c.red = 8'd255; c.green = 8'd255; c.blue = 8'(3 * (i - 170));
        end
      end
      pcm_pkg::MODE_COLD: begin
        c.red = idx; c.green = 8'(255 - i); c.blue = 8'd255;
      end
      pcm_pkg::MODE_RAIN: c = rainbow_color(idx);
      pcm_pkg::MODE_RAIN2, pcm_pkg::MODE_RAIN4, pcm_pkg::MODE_RAIN8,
      pcm_pkg::MODE_RAIN16, pcm_pkg::MODE_RAIN32: begin
        // 2^(mode-5) levels: index rounded down to a multiple of 256/levels
        drop = pcm_pkg::PIX_W - (int'(mode) - int'(pcm_pkg::MODE_RAIN));
        c = rainbow_color(8'((i >> drop) << drop));
      end
      default: c = '0; // unused codes give black
    endcase
    return c;
  endfunction

  // ---------------------------------------------------------------------------
  // Transfer monitor, result checker and watchdog. Everything is sampled at the
  // rising edge, before any nonblocking update of that edge lands.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    rgb_t want;
    bit   input_xfer;
    input_xfer = rst_n && start && !busy;

    // Expectation is computed with the palette in force at the transfer edge.
    if (input_xfer)
      expected_colors.push_back(palette_color(active_mode, in_pixel_index));
    if (rst_n && cfg_we)
      active_mode = cfg_wdata;

    if (rst_n && out_valid) begin
      if (expected_colors.size() == 0) begin
        $display("%0t: unexpected result: expected none, actual r=%0d g=%0d b=%0d",
                 $time, out_red, out_green, out_blue);
        error_count++;
      end else begin
        want = expected_colors.pop_front();
        if (out_red !== want.red) begin
          $display("%0t: red mismatch: expected %0d, actual %0d", $time, want.red, out_red);
          error_count++;
        end
        if (out_green !== want.green) begin
          $display("%0t: green mismatch: expected %0d, actual %0d",
                   $time, want.green, out_green);
          error_count++;
        end
        if (out_blue !== want.blue) begin
          $display("%0t: blue mismatch: expected %0d, actual %0d",
                   $time, want.blue, out_blue);
          error_count++;
        end
      end
    end

    // Timeout: any transfer on either side resets the count.
    if (input_xfer || (rst_n && out_valid))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("%0t: timeout, %0d colors still pending", $time, expected_colors.size());
      $display("pseudocolor_palette_mapper test failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers. Each is entered and left on a rising edge; start stays
  // high from one transfer to the next so back-to-back pixels need no toggle.
  // ---------------------------------------------------------------------------

  // Present one pixel and hold it until the block takes it (busy low at the edge).
  task automatic send_pixel(input logic [pcm_pkg::PIX_W-1:0] idx);
    start          <= 1'b1;
    in_pixel_index <= idx;
    do @(posedge clk); while (busy);
  endtask

  // Drop start and wait until every predicted color has come out.
  task automatic settle_pipeline();
    start <= 1'b0;
    do @(posedge clk); while (expected_colors.size() != 0);
    repeat (PIPE_LATENCY) @(posedge clk);
  endtask

  // Register write; only called with the pipeline empty.
  task automatic write_palette_mode(input logic [pcm_pkg::MODE_W-1:0] mode);
    cfg_we    <= 1'b1;
    cfg_wdata <= mode;
    @(posedge clk);
    cfg_we    <= 1'b0;
    written_mode = mode;
  endtask

  // Send one pixel under a given palette, switching the palette if needed.
  task automatic send_under_mode(input logic [pcm_pkg::MODE_W-1:0] mode,
                                 input logic [pcm_pkg::PIX_W-1:0]  idx);
    if (mode != written_mode) begin
      settle_pipeline();
      write_palette_mode(mode);
    end
    send_pixel(idx);
  endtask

  // Sender pacing: random bursts separated by random gaps, so a gap can land on
  // any stage of the four-deep pipeline.
  task automatic pace_sender();
    int gap;
    if (no_gaps) return;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, MAX_BURST);
      gap        = $urandom_range(0, MAX_GAP);
      if (gap != 0) begin
        start <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
  endtask

  // Mostly uniform indices, with a share landing on segment boundaries.
  function automatic logic [pcm_pkg::PIX_W-1:0] pick_index();
    if ($urandom_range(0, 3) == 0)
      return BREAK_POINTS[$urandom_range(0, 11)];
    return 8'($urandom_range(0, 255));
  endfunction

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Out of reset the block must use the two-level rainbow without any write.
  task automatic test_reset_default();
    send_pixel(8'd127);
    send_pixel(8'd128);
    settle_pipeline();
  endtask

  // Segment boundaries and extremes of the linear palettes and the rainbow.
  task automatic test_palette_edges();
    send_under_mode(pcm_pkg::MODE_GRAY,    8'd255);
    send_under_mode(pcm_pkg::MODE_REDBLUE, 8'd0);
    send_under_mode(pcm_pkg::MODE_RGB,     8'd127);
    send_under_mode(pcm_pkg::MODE_RGB,     8'd128);
    send_under_mode(pcm_pkg::MODE_HOT,     8'd84);
    send_under_mode(pcm_pkg::MODE_HOT,     8'd85);
    send_under_mode(pcm_pkg::MODE_HOT,     8'd169);
    send_under_mode(pcm_pkg::MODE_HOT,     8'd170);
    send_under_mode(pcm_pkg::MODE_HOT,     8'd255);
    send_under_mode(pcm_pkg::MODE_COLD,    8'd0);
    foreach (BREAK_POINTS[k])
      if (BREAK_POINTS[k] != 8'd84 && BREAK_POINTS[k] != 8'd85 &&
          BREAK_POINTS[k] != 8'd169 && BREAK_POINTS[k] != 8'd170)
        send_under_mode(pcm_pkg::MODE_RAIN, BREAK_POINTS[k]);
    settle_pipeline();
  endtask

  // Codes with no palette must give black, including the top code.
  task automatic test_unused_modes();
    send_under_mode(MODE_UNUSED_FIRST, 8'd0);
    send_under_mode(MODE_LAST,         8'd255);
    settle_pipeline();
  endtask

  // Every code 0..15 once, in random order, each with a run of random pixels.
  task automatic test_random_palettes();
    logic [pcm_pkg::MODE_W-1:0] order [NUM_MODES];
    logic [pcm_pkg::MODE_W-1:0] tmp;
    int                         j;
    for (int m = 0; m < NUM_MODES; m++)
      order[m] = m[pcm_pkg::MODE_W-1:0];
    for (int m = NUM_MODES - 1; m > 0; m--) begin
      j        = $urandom_range(0, m);
      tmp      = order[m];
      order[m] = order[j];
      order[j] = tmp;
    end
    for (int m = 0; m < NUM_MODES; m++) begin
      settle_pipeline();
      write_palette_mode(order[m]);
      no_gaps    = ($urandom_range(0, 3) == 0); // some phases run at full rate
      burst_left = 0;
      for (int n = 0; n < ITEMS_PER_MODE; n++) begin
        pace_sender();
        send_pixel(pick_index());
      end
    end
    settle_pipeline();
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_default();
    test_palette_edges();
    test_unused_modes();
    test_random_palettes();

    if (error_count == 0)
      $display("pseudocolor_palette_mapper test passed");
    else
      $display("pseudocolor_palette_mapper test failed");
    $finish;
  end

endmodule
`default_nettype wire

// File: sim.f
rtl/pcm_pkg.sv
rtl/pcm_decode.sv
rtl/pcm_ramp.sv
rtl/pcm_select.sv
rtl/pseudocolor_palette_mapper.sv
rtl/pcm_checker.sv
tb/tb_pseudocolor_palette_mapper.sv
